// File: hw/rtl/histogram_chi_square_accumulator_assert.svh
// Assertion macros shared by the chi-square accumulator RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef HISTOGRAM_CHI_SQUARE_ACCUMULATOR_ASSERT_SVH
`define HISTOGRAM_CHI_SQUARE_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the trigger.
`define HCSA_ASSERT_SAME(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define HCSA_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/hcsa_pkg.sv
// Shared types and constants of the chi-square accumulator.
// No dependencies.
package hcsa_pkg;

	localparam int DATA_W        = 32;
	localparam int NUM_W         = 128;
	localparam int DEN_W         = 97;
	localparam int OUT_W         = 63;
	localparam int SUM_WIDTH_DEF = 63;
	localparam int QUEUE_DEPTH   = 2;
	// Numerators of the error and Pearson modes fit in the low 66 bits.
	localparam int NARROW_STEPS  = 66;
	localparam int NARROW_SHIFT  = NUM_W - NARROW_STEPS;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_MODE      = 2'd0;
	localparam logic [1:0] REG_OBS_TOTAL = 2'd1;
	localparam logic [1:0] REG_EXP_TOTAL = 2'd2;

	// Statistic modes.
	localparam logic [1:0] MODE_ERROR   = 2'd0;
	localparam logic [1:0] MODE_SHAPE   = 2'd1;
	localparam logic [1:0] MODE_PEARSON = 2'd2;

	// One classified bin, passed from the front end to the divider.
	typedef struct packed {
		logic              have;
		logic              wide;
		logic              last;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} q_entry_t;

endpackage

// File: hw/rtl/histogram_chi_square_accumulator.sv
// Channel   Dir  Handshake                Payload
// cfg       in   cfg_valid / cfg_ready    cfg_index, cfg_data
// s_        in   s_tvalid / s_tready      s_tdata (four counts), s_tlast
// m_        out  m_tvalid / m_tready      m_tdata (sum and two flags)
//
// A bin passes the front end (the shared 32x32 multiplier and, in error mode, a
// 33-step root) and then the back end, where the one-bit-per-cycle divider sets
// the rate; it runs more quotient steps in shape mode than in error and Pearson
// mode. Empty bins skip the multiplier and the divider.
// arst_n clears all control state and the running sum at once; no clearing pass.
// The two-entry queue lets the front end take new bins while the divider works
// or while a result waits on m_tready.
module histogram_chi_square_accumulator import hcsa_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [DATA_W-1:0]   cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// observed_count, expected_count, observed_error, expected_error
	input  logic [4*DATA_W-1:0] s_tdata,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	// chi_square [62:0], overflowed [63], zero_denominator [64], zeros above
	output logic [71:0]         m_tdata
);

	logic     push_valid, push_ready, pop_valid, pop_ready;
	q_entry_t push_entry, pop_entry;

	hcsa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	hcsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	hcsa_back #(
		.SUM_WIDTH (SUM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: hw/rtl/hcsa_front.sv
// Front end: configuration registers, bin intake and operand preparation.
// Builds numerator and denominator with one shared multiplier and a root unit.
module hcsa_front import hcsa_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [DATA_W-1:0]   cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [4*DATA_W-1:0] s_tdata,
	input  logic                s_tlast,
	output logic                push_valid,
	input  logic                push_ready,
	output q_entry_t            push_entry
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_SQRT = 2'd2;
	localparam logic [1:0] ST_PUSH = 2'd3;

	// What to do with a product in the cycle after it is formed.
	localparam logic [3:0] TG_NONE  = 4'd0;
	localparam logic [3:0] TG_NSET  = 4'd1;
	localparam logic [3:0] TG_NSET2 = 4'd2;
	localparam logic [3:0] TG_N32   = 4'd3;
	localparam logic [3:0] TG_N64   = 4'd4;
	localparam logic [3:0] TG_TSET  = 4'd5;
	localparam logic [3:0] TG_TADD  = 4'd6;
	localparam logic [3:0] TG_A     = 4'd7;
	localparam logic [3:0] TG_B     = 4'd8;
	localparam logic [3:0] TG_EN2   = 4'd9;
	localparam logic [3:0] TG_ON2   = 4'd10;
	localparam logic [3:0] TG_DSET  = 4'd11;
	localparam logic [3:0] TG_D0    = 4'd12;
	localparam logic [3:0] TG_D32   = 4'd13;

	localparam int RAD_W  = 66;
	localparam int ROOT_W = 33;
	localparam int REM_W  = 36;

	logic [1:0]        mode_q;
	logic [DATA_W-1:0] on_q, en_q;
	logic [1:0]        state_q;
	logic [3:0]        step_q;
	logic [1:0]        bmode_q;
	logic [DATA_W-1:0] o_q, e_q, eo_q, ee_q, d_q;
	logic              last_q, have_q;
	logic [63:0]       prod_q;
	logic [3:0]        tag_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [RAD_W-1:0]  rad_q;
	logic [63:0]       ta_q, dd_q, en2_q, on2_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [5:0]        sq_cnt_q;

	logic [DATA_W-1:0] in_o, in_e, in_eo, in_ee;
	logic [DATA_W-1:0] mul_a, mul_b;
	logic [3:0]        iss_tag;
	logic              iss_end;
	logic [REM_W-1:0]  rem_sh, trial;

	assign in_o  = s_tdata[DATA_W-1:0];
	assign in_e  = s_tdata[2*DATA_W-1:DATA_W];
	assign in_eo = s_tdata[3*DATA_W-1:2*DATA_W];
	assign in_ee = s_tdata[4*DATA_W-1:3*DATA_W];

	assign cfg_ready  = 1'b1;
	assign s_tready   = (state_q == ST_IDLE);
	assign push_valid = (state_q == ST_PUSH);

	always_comb begin
		push_entry.have = have_q;
		push_entry.wide = (bmode_q == MODE_SHAPE);
		push_entry.last = last_q;
		push_entry.num  = num_q;
		push_entry.den  = den_q;
	end

	// Configuration register file; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ERROR;
			on_q   <= '0;
			en_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:      mode_q <= cfg_data[1:0];
				REG_OBS_TOTAL: on_q   <= cfg_data;
				REG_EXP_TOTAL: en_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	// Multiply schedule for each mode; the last step only drains the product.
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		iss_tag = TG_NONE;
		iss_end = 1'b0;
		case (bmode_q)
			MODE_ERROR: begin
				case (step_q)
					4'd0: begin mul_a = d_q;  mul_b = d_q;  iss_tag = TG_NSET; end
					4'd1: begin mul_a = eo_q; mul_b = eo_q; iss_tag = TG_TSET; end
					4'd2: begin mul_a = ee_q; mul_b = ee_q; iss_tag = TG_TADD; end
					default: iss_end = 1'b1;
				endcase
			end
			MODE_SHAPE: begin
				case (step_q)
					4'd0: begin mul_a = o_q;  mul_b = en_q; iss_tag = TG_A; end
					4'd1: begin mul_a = e_q;  mul_b = on_q; iss_tag = TG_B; end
					4'd2: begin mul_a = en_q; mul_b = en_q; iss_tag = TG_EN2; end
					4'd3: begin mul_a = on_q; mul_b = on_q; iss_tag = TG_ON2; end
					4'd4: begin mul_a = dd_q[31:0];  mul_b = dd_q[31:0];  iss_tag = TG_NSET; end
					4'd5: begin mul_a = dd_q[31:0];  mul_b = dd_q[63:32]; iss_tag = TG_N32; end
					4'd6: begin mul_a = dd_q[63:32]; mul_b = dd_q[31:0];  iss_tag = TG_N32; end
					4'd7: begin mul_a = dd_q[63:32]; mul_b = dd_q[63:32]; iss_tag = TG_N64; end
					4'd8: begin mul_a = o_q; mul_b = en2_q[31:0];  iss_tag = TG_DSET; end
					4'd9: begin mul_a = o_q; mul_b = en2_q[63:32]; iss_tag = TG_D32; end
					4'd10: begin mul_a = e_q; mul_b = on2_q[31:0];  iss_tag = TG_D0; end
					4'd11: begin mul_a = e_q; mul_b = on2_q[63:32]; iss_tag = TG_D32; end
					default: iss_end = 1'b1;
				endcase
			end
			default: begin
				case (step_q)
					4'd0: begin mul_a = d_q; mul_b = d_q; iss_tag = TG_NSET2; end
					default: iss_end = 1'b1;
				endcase
			end
		endcase
	end

	// One root digit per cycle: bring in two radicand bits, try 4r+1.
	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
	assign trial  = {1'b0, root_q, 2'b01};

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			tag_q   <= TG_NONE;
		end else begin
			tag_q <= TG_NONE;
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						step_q  <= '0;
						if ((in_o == '0 && in_e == '0) || mode_q > MODE_PEARSON) begin
							state_q <= ST_PUSH;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					step_q <= step_q + 4'd1;
					tag_q  <= iss_tag;
					if (iss_end) begin
						state_q <= (bmode_q == MODE_ERROR) ? ST_SQRT : ST_PUSH;
					end
				end
				ST_SQRT: begin
					if (sq_cnt_q == 6'd1) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (state_q == ST_IDLE && s_tvalid) begin
			o_q     <= in_o;
			e_q     <= in_e;
			eo_q    <= in_eo;
			ee_q    <= in_ee;
			d_q     <= (in_o > in_e) ? in_o - in_e : in_e - in_o;
			last_q  <= s_tlast;
			bmode_q <= mode_q;
			have_q  <= !((in_o == '0 && in_e == '0) || mode_q > MODE_PEARSON);
			den_q   <= DEN_W'({1'b0, in_o} + {1'b0, in_e});
			num_q   <= '0;
		end
		// Fold the previous product into its destination.
		case (tag_q)
			TG_NSET:  num_q <= NUM_W'(prod_q);
			TG_NSET2: num_q <= NUM_W'({prod_q, 1'b0});
			TG_N32:   num_q <= num_q + (NUM_W'(prod_q) << 32);
			TG_N64:   num_q <= num_q + (NUM_W'(prod_q) << 64);
			TG_TSET:  rad_q <= RAD_W'(prod_q);
			TG_TADD:  rad_q <= rad_q + RAD_W'(prod_q);
			TG_A:     ta_q  <= prod_q;
			TG_B:     dd_q  <= (ta_q > prod_q) ? ta_q - prod_q : prod_q - ta_q;
			TG_EN2:   en2_q <= prod_q;
			TG_ON2:   on2_q <= prod_q;
			TG_DSET:  den_q <= DEN_W'(prod_q);
			TG_D0:    den_q <= den_q + DEN_W'(prod_q);
			TG_D32:   den_q <= den_q + (DEN_W'(prod_q) << 32);
			default:  ;
		endcase
		// Root unit.
		if (state_q == ST_MUL && iss_end) begin
			rem_q    <= '0;
			root_q   <= '0;
			sq_cnt_q <= 6'(ROOT_W);
		end else if (state_q == ST_SQRT) begin
			rad_q    <= {rad_q[RAD_W-3:0], 2'b00};
			sq_cnt_q <= sq_cnt_q - 6'd1;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
			if (sq_cnt_q == 6'd1) begin
				den_q <= DEN_W'({root_q[ROOT_W-2:0], rem_sh >= trial});
			end
		end
	end

endmodule

// File: hw/rtl/hcsa_queue.sv
// Two-entry queue between the front end and the divider.
// Depends on hcsa_pkg and the shared assertion macros.
`include "histogram_chi_square_accumulator_assert.svh"
module hcsa_queue import hcsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  q_entry_t push_entry,
	output logic     pop_valid,
	input  logic     pop_ready,
	output q_entry_t pop_entry
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	q_entry_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	`HCSA_ASSERT_SAME(a_count_range, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
	`HCSA_ASSERT_NEXT(a_count_up, do_push && !do_pop, count_q == $past(count_q) + 1'b1, "push lost")
	`HCSA_ASSERT_NEXT(a_count_down, do_pop && !do_push, count_q == $past(count_q) - 1'b1, "pop lost")

endmodule

// File: hw/rtl/hcsa_back.sv
// Back end: restoring divider, saturating accumulator and result register.
// Depends on hcsa_pkg and the shared assertion macros.
`include "histogram_chi_square_accumulator_assert.svh"
module hcsa_back import hcsa_pkg::*; #(
	parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  q_entry_t         pop_entry,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [71:0]      m_tdata
);

	localparam logic [1:0] B_IDLE = 2'd0;
	localparam logic [1:0] B_DIV  = 2'd1;
	localparam logic [1:0] B_ACC  = 2'd2;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_W-1:0]     n_q;
	logic [DEN_W-1:0]     d_q, r_q;
	logic [SUM_WIDTH-1:0] quo_q, sum_q;
	logic                 big_q, use_q, last_q, ovf_q, zd_q;
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_chi_q;
	logic                 out_ovf_q, out_zd_q;

	logic [DEN_W:0]       r_sh;
	logic                 qbit;
	logic [SUM_WIDTH:0]   sum_add;
	logic                 sat;
	logic [SUM_WIDTH-1:0] sum_new;
	logic                 ovf_new;
	logic [63:0]          sum_ext;
	logic                 emit;

	assign pop_ready = (state_q == B_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {7'd0, out_zd_q, out_ovf_q, out_chi_q};

	// One quotient bit per cycle.
	assign r_sh = {r_q, n_q[NUM_W-1]};
	assign qbit = (r_sh >= {1'b0, d_q});

	// Saturating add of the finished term.
	assign sum_add = {1'b0, sum_q} + {1'b0, quo_q};
	assign sat     = use_q && (big_q || sum_add[SUM_WIDTH]);
	assign sum_new = sat ? SUM_MAX : (use_q ? sum_add[SUM_WIDTH-1:0] : sum_q);
	assign ovf_new = ovf_q || sat;
	assign sum_ext = 64'(sum_new);
	assign emit    = (state_q == B_ACC) && last_q && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			zd_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						if (pop_entry.have && pop_entry.den != '0) begin
							state_q <= B_DIV;
						end else begin
							state_q <= B_ACC;
							if (pop_entry.have) begin
								zd_q <= 1'b1;
							end
						end
					end
				end
				B_DIV: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= B_ACC;
					end
				end
				B_ACC: begin
					if (!last_q) begin
						sum_q   <= sum_new;
						ovf_q   <= ovf_new;
						state_q <= B_IDLE;
					end else if (emit) begin
						sum_q       <= '0;
						ovf_q       <= 1'b0;
						zd_q        <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Divider datapath and result register.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && pop_valid) begin
			n_q    <= pop_entry.wide ? pop_entry.num : (pop_entry.num << NARROW_SHIFT);
			cnt_q  <= pop_entry.wide ? CNT_W'(NUM_W) : CNT_W'(NARROW_STEPS);
			d_q    <= pop_entry.den;
			r_q    <= '0;
			quo_q  <= '0;
			big_q  <= 1'b0;
			use_q  <= pop_entry.have && pop_entry.den != '0;
			last_q <= pop_entry.last;
		end else if (state_q == B_DIV) begin
			n_q   <= {n_q[NUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
			r_q   <= qbit ? DEN_W'(r_sh - {1'b0, d_q}) : DEN_W'(r_sh);
			quo_q <= {quo_q[SUM_WIDTH-2:0], qbit};
			big_q <= big_q || quo_q[SUM_WIDTH-1];
		end
		if (emit) begin
			out_chi_q <= sum_ext[63] ? '1 : sum_ext[OUT_W-1:0];
			out_ovf_q <= ovf_new;
			out_zd_q  <= zd_q;
		end
	end

	`HCSA_ASSERT_NEXT(a_clear_after_emit, emit, sum_q == '0 && !ovf_q && !zd_q, "sum not cleared")
	`HCSA_ASSERT_SAME(a_ovf_pinned, ovf_q, sum_q == SUM_MAX, "overflow without saturated sum")
	`HCSA_ASSERT_SAME(a_div_count, state_q == B_DIV, cnt_q != '0, "divider ran past its steps")

endmodule
